// ----- hw/rtl/mrs_pkg.sv -----
`default_nettype none
package mrs_pkg;

	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned POS_W = $clog2(FRAME_LEN);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] ADDR_RESET = 8'h01;
	localparam logic [7:0] FN_READ_HOLDING = 8'h03;
	localparam logic [7:0] FN_READ_INPUT = 8'h04;
	localparam logic [7:0] FN_WRITE_COIL = 8'h05;
	localparam logic [7:0] BYTE_COUNT_REPLY = 8'h02;
	localparam logic [7:0] COIL_ON_HI = 8'hFF;
	localparam logic [7:0] COIL_LO = 8'h00;

	localparam int unsigned REPLY_LEN = 7;
	localparam logic [8:0] TEMP_SCALE = 9'd500;
	localparam int unsigned TEMP_SHIFT = 10;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/modbus_rtu_slave_frame_handler.sv -----
// Sequence: each request byte is taken on its own handshake; after the eighth byte an
// evaluation state follows, then each reply byte passes through a frame store read, an
// output register load and a transfer that waits while m_tready stays low.
// Throughput: one request byte per cycle while a frame is gathered; no input during evaluation or a reply.
// Reset (arst_n low, asynchronous): no open frame, relay off, slave address 1;
// the frame store is not cleared.
`default_nettype none
module modbus_rtu_slave_frame_handler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// rx_byte [7:0], temperature_adc [17:8], zero [23:18]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tx_byte [7:0], relay_on [8], zero [15:9]
	output logic [15:0]      m_tdata,
	output logic             m_tlast
);

	localparam int unsigned PW = mrs_pkg::POS_W;
	localparam logic [1:0] ST_RX   = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0]    state_q;
	logic          wait_q;
	logic [7:0]    addr_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   crc_q;
	logic          relay_q;
	logic [7:0]    fn_q, d4_q, d5_q, b6_q, b7_q;
	logic [9:0]    adc_q;
	logic [8:0]    temp_q;
	logic          echo_q;
	logic [PW-1:0] idx_q;
	logic [15:0]   rcrc_q;
	logic          m_tvalid_q;
	logic [7:0]    tx_byte_q;
	logic          tx_last_q;
	logic          relay_out_q;

	logic [7:0] frame_mem [mrs_pkg::FRAME_LEN];
	logic [7:0] rd_q;

	logic [7:0]  rx_b;
	logic        s_xfer, take, cfg_wr;
	logic [18:0] prod;
	logic        crc_ok, fn_reply;
	logic [7:0]  reply_b, load_b;
	logic        load_last;

	assign rx_b = s_tdata[7:0];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {24'd0, addr_q};
	assign cfg_wr = psel && penable && pwrite && !paddr[2];

	assign s_tready = (state_q == ST_RX);
	assign s_xfer = s_tvalid && s_tready;
	assign take = s_xfer && ((pos_q != '0) || (rx_b == addr_q));

	assign prod = 19'(adc_q) * 19'(mrs_pkg::TEMP_SCALE);
	assign crc_ok = ({b7_q, b6_q} == crc_q);
	assign fn_reply = (fn_q == mrs_pkg::FN_READ_HOLDING) || (fn_q == mrs_pkg::FN_READ_INPUT);

	always_comb begin
		unique case (idx_q)
			3'd0: reply_b = addr_q;
			3'd1: reply_b = fn_q;
			3'd2: reply_b = mrs_pkg::BYTE_COUNT_REPLY;
			3'd3: reply_b = {7'd0, temp_q[8]};
			3'd4: reply_b = temp_q[7:0];
			3'd5: reply_b = rcrc_q[7:0];
			default: reply_b = rcrc_q[15:8];
		endcase
		load_b = echo_q ? rd_q : reply_b;
		load_last = echo_q ? (idx_q == PW'(mrs_pkg::FRAME_LEN - 1))
			: (idx_q == PW'(mrs_pkg::REPLY_LEN - 1));
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_mem[pos_q] <= rx_b;
		end
		rd_q <= frame_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (pos_q)
				3'd1: fn_q <= rx_b;
				3'd4: d4_q <= rx_b;
				3'd5: d5_q <= rx_b;
				3'd6: b6_q <= rx_b;
				3'd7: begin
					b7_q <= rx_b;
					adc_q <= s_tdata[17:8];
				end
				default: ;
			endcase
		end
		if (state_q == ST_EVAL) begin
			temp_q <= prod[18:mrs_pkg::TEMP_SHIFT];
		end
		if (state_q == ST_LOAD && !wait_q) begin
			tx_byte_q <= load_b;
			tx_last_q <= load_last;
			relay_out_q <= relay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
			wait_q <= 1'b0;
			addr_q <= mrs_pkg::ADDR_RESET;
			pos_q <= '0;
			crc_q <= mrs_pkg::CRC_INIT;
			relay_q <= 1'b0;
			echo_q <= 1'b0;
			idx_q <= '0;
			rcrc_q <= mrs_pkg::CRC_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				addr_q <= pwdata[7:0];
			end
			unique case (state_q)
				ST_RX: begin
					if (take) begin
						pos_q <= pos_q + PW'(1);
						if (pos_q == '0) begin
							crc_q <= mrs_pkg::crc_feed(mrs_pkg::CRC_INIT, rx_b);
						end else if (pos_q < PW'(6)) begin
							crc_q <= mrs_pkg::crc_feed(crc_q, rx_b);
						end
						if (pos_q == PW'(mrs_pkg::FRAME_LEN - 1)) begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					idx_q <= '0;
					rcrc_q <= mrs_pkg::CRC_INIT;
					if (crc_ok && fn_q == mrs_pkg::FN_WRITE_COIL) begin
						echo_q <= 1'b1;
						state_q <= ST_READ;
						if (d4_q == mrs_pkg::COIL_ON_HI && d5_q == mrs_pkg::COIL_LO) begin
							relay_q <= 1'b1;
						end else if (d4_q == mrs_pkg::COIL_LO && d5_q == mrs_pkg::COIL_LO) begin
							relay_q <= 1'b0;
						end
					end else if (crc_ok && fn_reply) begin
						echo_q <= 1'b0;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_RX;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				default: begin
					if (!wait_q) begin
						m_tvalid_q <= 1'b1;
						wait_q <= 1'b1;
						if (!echo_q && idx_q < PW'(5)) begin
							rcrc_q <= mrs_pkg::crc_feed(rcrc_q, load_b);
						end
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
						wait_q <= 1'b0;
						idx_q <= idx_q + PW'(1);
						state_q <= tx_last_q ? ST_RX : ST_READ;
					end
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'd0, relay_out_q, tx_byte_q};
	assign m_tlast = tx_last_q;

endmodule
`default_nettype wire
